// File: design/gcbhm_pkg.sv
// shared types, codes and constants of the grouped control-byte hash map
package gcbhm_pkg;

  // default sizing of the table
  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_KEY_WIDTH = 32;

  // slots per probe group, and the lane index width inside a group
  localparam int GROUP_SLOTS = 4;
  localparam int LANE_W      = 2;

  // hash layout: low bits carry the tag, the rest the home position
  localparam int HASH_W = 64;
  localparam int TAG_W  = 7;
  localparam int HOME_W = HASH_W - TAG_W;

  // control byte values
  localparam int          CTRL_W        = 8;
  localparam int          CTRL_FREE_BIT = 7;
  localparam logic [7:0]  CTRL_EMPTY    = 8'hFF;
  localparam logic [7:0]  CTRL_DELETED  = 8'h80;

  // operation codes
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_FIND   = 2'd1;
  localparam kind_t KIND_DELETE = 2'd2;
  localparam kind_t KIND_UNUSED = 2'd3;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_FOUND    = 2'd0;
  localparam status_t ST_INSERTED = 2'd1;
  localparam status_t ST_DELETED  = 2'd2;
  localparam status_t ST_ABSENT   = 2'd3;

  typedef logic [LANE_W-1:0] lane_t;

  // outcome of comparing one group of slots
  typedef struct packed {
    logic  hit;
    lane_t hit_lane;
    logic  free;
    lane_t free_lane;
  } probe_t;

endpackage

// File: design/gcbhm_ram.sv
// generic single write port, single read port ram with registered read
module gcbhm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/gcbhm_grp_cmp.sv
// tag, key and free-slot compare over one group of four slots
module gcbhm_grp_cmp #(
  parameter int KEY_WIDTH = gcbhm_pkg::DEF_KEY_WIDTH
) (
  input  logic [gcbhm_pkg::GROUP_SLOTS*gcbhm_pkg::CTRL_W-1:0] ctrl_row,
  input  logic [gcbhm_pkg::GROUP_SLOTS*KEY_WIDTH-1:0]         key_row,
  input  logic [gcbhm_pkg::TAG_W-1:0]                         tag,
  input  logic [KEY_WIDTH-1:0]                                key,
  output gcbhm_pkg::probe_t                                   probe
);
  import gcbhm_pkg::*;

  // lanes are independent; walking from the top lane down leaves the lowest match
  always_comb begin
    probe = '0;
    for (int j = GROUP_SLOTS - 1; j >= 0; j--) begin
      if (ctrl_row[j*CTRL_W +: CTRL_W] == {1'b0, tag} &&
          key_row[j*KEY_WIDTH +: KEY_WIDTH] == key) begin
        probe.hit      = 1'b1;
        probe.hit_lane = LANE_W'(j);
      end
      if (ctrl_row[j*CTRL_W + CTRL_FREE_BIT]) begin
        probe.free      = 1'b1;
        probe.free_lane = LANE_W'(j);
      end
    end
  end

endmodule

// File: design/grouped_control_byte_hash_map.sv
// top level of the grouped control-byte hash map with group-wise probing
//
//  channel   ports                                          transfer when
//  in        in_valid, in_stall, in_kind, in_hash_value,   in_valid && !in_stall
//            in_key
//  out       out_valid, out_stall, out_status,             out_valid && !out_stall
//            out_slot_index, out_occupied_count
//
// One operation at a time: the transfer is taken, the first group is read, then the
// probed groups follow in turn (a group row comes out of the memories each cycle).
// A capacity that is not a power of two adds the home position reduction, byte by
// byte: a quotient estimate by reciprocal, then a subtract and correction on the add
// and compare unit shared with the probe step. After reset a clearing pass writes
// one group row a cycle, with in_stall high. A stalled result waits in the output
// register; the next operation may start meanwhile and holds in its last probe cycle
// until the register is free.
module grouped_control_byte_hash_map #(
  parameter int CAPACITY  = gcbhm_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = gcbhm_pkg::DEF_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gcbhm_pkg::kind_t                 in_kind,
  input  logic [gcbhm_pkg::HASH_W-1:0]     in_hash_value,
  input  logic [KEY_WIDTH-1:0]             in_key,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gcbhm_pkg::status_t               out_status,
  output logic [7:0]                       out_slot_index,
  output logic [8:0]                       out_occupied_count
);
  import gcbhm_pkg::*;

  localparam int GROUPS     = (CAPACITY + GROUP_SLOTS - 1) / GROUP_SLOTS;
  localparam int SLOT_TOTAL = GROUPS * GROUP_SLOTS;
  localparam int PW         = $clog2(CAPACITY);
  localparam int RW         = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW         = $clog2(SLOT_TOTAL);
  localparam int LW         = $clog2(SLOT_TOTAL + 1);
  localparam int MOD_DIG    = (HOME_W + 7) / 8;
  localparam int HV_W       = MOD_DIG * 8;
  localparam int CW         = $clog2(2 * MOD_DIG);
  localparam int VW         = PW + 8;
  localparam bit CAP_POW2   = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int CTRL_ROW_W = GROUP_SLOTS * CTRL_W;
  localparam int KEY_ROW_W  = GROUP_SLOTS * KEY_WIDTH;
  localparam logic [PW:0]   CAP_V    = (PW + 1)'(CAPACITY);
  localparam logic [8:0]    MOD_RCP  = 9'((1 << VW) / CAPACITY);
  localparam logic [RW-1:0] ROW_LAST = RW'(GROUPS - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(2 * MOD_DIG - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [RW-1:0]     clr_r, clr_nxt;
  logic [LW-1:0]     live_r, live_nxt;
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [HV_W-1:0]   hv_r, hv_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [7:0]        qe_r, qe_nxt;
  logic [RW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [7:0]        out_slot_r, out_slot_nxt;
  logic [8:0]        out_count_r, out_count_nxt;

  logic [PW:0]       red_in, red_out;
  logic [VW-1:0]     mod_v, mod_qc;
  logic [VW+8:0]     mod_prod;
  logic [RW-1:0]     row_cur, row_next;
  logic              out_free;
  logic              finish;
  status_t           res_status;
  logic [SW-1:0]     res_slot;

  logic                  ctrl_we, key_we, rd_en;
  logic [RW-1:0]         wr_addr, rd_addr;
  logic [CTRL_ROW_W-1:0] ctrl_wdata, ctrl_rdata;
  logic [KEY_ROW_W-1:0]  key_wdata, key_rdata;
  probe_t                probe;

  // home reduction: fold in one byte, quotient estimated by reciprocal, at most one low
  assign mod_v    = {p_r, hv_r[HV_W-1 -: 8]};
  assign mod_prod = (VW + 9)'(mod_v) * (VW + 9)'(MOD_RCP);
  assign mod_qc   = VW'(qe_r) * VW'(CAP_V);

  // shared add and compare unit: home reduction correction, or step to next group
  always_comb begin
    if (state_r == S_MOD) begin
      red_in = (PW + 1)'(mod_v - mod_qc);
    end else begin
      red_in = (PW + 1)'(p_r) + (PW + 1)'(GROUP_SLOTS);
    end
    red_out = (red_in >= CAP_V) ? red_in - CAP_V : red_in;
  end

  assign row_cur  = RW'(p_r >> LANE_W);
  assign row_next = RW'(red_out >> LANE_W);

  // control byte rows
  gcbhm_ram #(
    .WIDTH  (CTRL_ROW_W),
    .DEPTH  (GROUPS),
    .ADDR_W (RW)
  ) u_ctrl_ram (
    .clk   (clk),
    .we    (ctrl_we),
    .waddr (wr_addr),
    .wdata (ctrl_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ctrl_rdata)
  );

  // key rows
  gcbhm_ram #(
    .WIDTH  (KEY_ROW_W),
    .DEPTH  (GROUPS),
    .ADDR_W (RW)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  // group compare on the row just read
  gcbhm_grp_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_grp_cmp (
    .ctrl_row (ctrl_rdata),
    .key_row  (key_rdata),
    .tag      (tag_r),
    .key      (key_r),
    .probe    (probe)
  );

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    live_nxt   = live_r;
    kind_nxt   = kind_r;
    tag_nxt    = tag_r;
    key_nxt    = key_r;
    hv_nxt     = hv_r;
    p_nxt      = p_r;
    qe_nxt     = qe_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    ctrl_we    = 1'b0;
    key_we     = 1'b0;
    wr_addr    = row_cur;
    ctrl_wdata = ctrl_rdata;
    key_wdata  = key_rdata;
    rd_en      = 1'b1;
    rd_addr    = row_cur;
    finish     = 1'b0;
    res_status = ST_ABSENT;
    res_slot   = '0;

    unique case (state_r)
      S_CLEAR: begin
        ctrl_we    = 1'b1;
        wr_addr    = clr_r;
        ctrl_wdata = {GROUP_SLOTS{CTRL_EMPTY}};
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == ROW_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          tag_nxt  = in_hash_value[TAG_W-1:0];
          key_nxt  = in_key;
          hv_nxt   = HV_W'(in_hash_value[HASH_W-1:TAG_W]);
          step_nxt = '0;
          cnt_nxt  = '0;
          if (in_kind == KIND_UNUSED) begin
            state_nxt = S_RESP;
          end else if (CAP_POW2) begin
            p_nxt     = in_hash_value[TAG_W +: PW];
            state_nxt = S_READ;
          end else begin
            p_nxt     = '0;
            state_nxt = S_MOD;
          end
        end
      end

      S_MOD: begin
        // even cycle estimates the quotient, odd cycle subtracts and corrects
        cnt_nxt = cnt_r + 1'b1;
        if (!cnt_r[0]) begin
          qe_nxt = mod_prod[VW +: 8];
        end else begin
          p_nxt  = PW'(red_out);
          hv_nxt = hv_r << 8;
        end
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        // first read the next group, on the chance this one ends nothing
        rd_addr = row_next;
        priority if (probe.hit) begin
          finish   = 1'b1;
          res_slot = SW'({row_cur, probe.hit_lane});
          if (kind_r == KIND_DELETE) begin
            res_status = ST_DELETED;
            ctrl_wdata[probe.hit_lane*CTRL_W +: CTRL_W] = CTRL_DELETED;
            ctrl_we  = out_free;
            live_nxt = out_free ? live_r - 1'b1 : live_r;
          end else begin
            res_status = ST_FOUND;
          end
        end else if (kind_r == KIND_INSERT && probe.free) begin
          finish     = 1'b1;
          res_slot   = SW'({row_cur, probe.free_lane});
          res_status = ST_INSERTED;
          ctrl_wdata[probe.free_lane*CTRL_W +: CTRL_W] = {1'b0, tag_r};
          key_wdata[probe.free_lane*KEY_WIDTH +: KEY_WIDTH] = key_r;
          ctrl_we  = out_free;
          key_we   = out_free;
          live_nxt = out_free ? live_r + 1'b1 : live_r;
        end else if (step_r == ROW_LAST) begin
          finish     = 1'b1;
          res_status = ST_ABSENT;
        end else begin
          p_nxt    = PW'(red_out);
          step_nxt = step_r + 1'b1;
        end
        if (finish) begin
          if (out_free) begin
            state_nxt = S_IDLE;
          end else begin
            // result register busy: keep this group's row in the read register
            rd_en   = 1'b0;
            rd_addr = row_cur;
          end
        end
      end

      S_RESP: begin
        finish = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    if (finish && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_slot_nxt   = 8'(res_slot);
      out_count_nxt  = 9'(live_nxt);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tag_r        <= tag_nxt;
    key_r        <= key_nxt;
    hv_r         <= hv_nxt;
    p_r          <= p_nxt;
    qe_r         <= qe_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_index     = out_slot_r;
  assign out_occupied_count = out_count_r;

endmodule

// File: verif/tb_grouped_control_byte_hash_map.sv
// self-checking testbench for the grouped control-byte hash map
module tb_grouped_control_byte_hash_map;
  timeunit 1ns;
  timeprecision 1ps;

  import gcbhm_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int KW           = DEF_KEY_WIDTH;
  localparam int HOME_BITS    = $clog2(CAP);
  localparam int MAX_WAIT     = 17;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS  = 40;
  localparam int KNOWN_DEPTH  = 400;

  typedef struct packed {
    kind_t             kind;
    logic [HASH_W-1:0] hash;
    logic [KW-1:0]     key;
  } map_op_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] slot;
    logic [8:0] count;
  } map_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  kind_t             in_kind = KIND_INSERT;
  logic [HASH_W-1:0] in_hash_value = '0;
  logic [KW-1:0]     in_key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  status_t           out_status;
  logic [7:0]        out_slot_index;
  logic [8:0]        out_occupied_count;

  // mirror of the table contents
  logic [CTRL_W-1:0] ctrl_mirror [CAP];
  logic [KW-1:0]     key_mirror [CAP];
  int                live_mirror;
  int                peak_live;

  map_op_t     op_backlog [$];
  map_reply_t  reply_due [$];
  map_op_t     known_ops [$];
  int unsigned hot_home [6];

  int          op_total;
  int          sent_count;
  int          mismatches;
  int          status_seen [4];
  int unsigned in_gap_left;
  bit          in_burst;
  int unsigned out_stall_left;
  bit          out_burst;
  int unsigned cycle_count;

  grouped_control_byte_hash_map #(
    .CAPACITY  (CAP),
    .KEY_WIDTH (KW)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_hash_value      (in_hash_value),
    .in_key             (in_key),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_occupied_count (out_occupied_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // probe groups from the home group on, updating the mirror
  function automatic map_reply_t apply_map_op(map_op_t op);
    logic [TAG_W-1:0] tag;
    int               home;
    int               base;
    int               s;
    int               step;
    int               j;
    bit               done;
    map_reply_t       r;
    tag = op.hash[TAG_W-1:0];
    home = int'((op.hash >> TAG_W) % CAP);
    r.status = ST_ABSENT;
    r.slot = '0;
    done = 1'b0;
    if (op.kind != KIND_UNUSED) begin
      for (step = 0; step < CAP && !done; step += GROUP_SLOTS) begin
        base = ((home + step) % CAP) & ~(GROUP_SLOTS - 1);
        // tag first, then key, across the group
        for (j = 0; j < GROUP_SLOTS && !done; j++) begin
          s = base + j;
          if (ctrl_mirror[s] == {1'b0, tag} && key_mirror[s] == op.key) begin
            done = 1'b1;
            r.slot = 8'(s);
            if (op.kind == KIND_DELETE) begin
              ctrl_mirror[s] = CTRL_DELETED;
              live_mirror--;
              r.status = ST_DELETED;
            end else begin
              r.status = ST_FOUND;
            end
          end
        end
        // insert takes the first empty or deleted slot of this group
        if (!done && op.kind == KIND_INSERT) begin
          for (j = 0; j < GROUP_SLOTS && !done; j++) begin
            s = base + j;
            if (ctrl_mirror[s][CTRL_FREE_BIT]) begin
              done = 1'b1;
              ctrl_mirror[s] = {1'b0, tag};
              key_mirror[s] = op.key;
              live_mirror++;
              r.slot = 8'(s);
              r.status = ST_INSERTED;
            end
          end
        end
      end
    end
    r.count = 9'(live_mirror);
    return r;
  endfunction

  function automatic logic [HASH_W-1:0] make_hash(int unsigned home, int unsigned tag);
    logic [HASH_W-1:0] h;
    h = {$urandom(), $urandom()};
    h[TAG_W +: HOME_BITS] = HOME_BITS'(home);
    h[TAG_W-1:0] = TAG_W'(tag);
    return h;
  endfunction

  function automatic void queue_op(kind_t kind, logic [HASH_W-1:0] hash, logic [KW-1:0] key);
    map_op_t op;
    op.kind = kind;
    op.hash = hash;
    op.key = key;
    op_backlog.push_back(op);
  endfunction

  // new entry, clustered on a few homes and tags to force collisions
  function automatic map_op_t fresh_op(kind_t kind);
    map_op_t     op;
    int unsigned home;
    int unsigned tag;
    home = ($urandom_range(0, 99) < 40) ? hot_home[$urandom_range(0, 5)]
                                         : $urandom_range(0, CAP - 1);
    tag = ($urandom_range(0, 99) < 40) ? $urandom_range(0, 3) : $urandom_range(0, 127);
    op.kind = kind;
    op.hash = make_hash(home, tag);
    op.key = ($urandom_range(0, 99) < 30) ? KW'($urandom_range(0, 15)) : KW'($urandom());
    return op;
  endfunction

  // earlier entry again, upper hash bits scrambled since they do not matter
  function automatic map_op_t recalled_op(kind_t kind);
    map_op_t           op;
    logic [HASH_W-1:0] h;
    op = known_ops[$urandom_range(0, known_ops.size() - 1)];
    h = {$urandom(), $urandom()};
    h[TAG_W+HOME_BITS-1:0] = op.hash[TAG_W+HOME_BITS-1:0];
    op.hash = h;
    op.kind = kind;
    return op;
  endfunction

  function automatic void queue_random_op(int unsigned ins_pct, int unsigned find_pct,
                                          int unsigned del_pct);
    int unsigned pick;
    bit          reuse;
    map_op_t     op;
    pick = $urandom_range(0, 99);
    reuse = known_ops.size() > 0 && $urandom_range(0, 99) < 70;
    if (pick < ins_pct) begin
      if (known_ops.size() > 0 && $urandom_range(0, 99) < 15) begin
        op = recalled_op(KIND_INSERT);
      end else begin
        op = fresh_op(KIND_INSERT);
        known_ops.push_back(op);
        if (known_ops.size() > KNOWN_DEPTH) void'(known_ops.pop_front());
      end
    end else if (pick < ins_pct + find_pct) begin
      op = reuse ? recalled_op(KIND_FIND) : fresh_op(KIND_FIND);
    end else if (pick < ins_pct + find_pct + del_pct) begin
      op = reuse ? recalled_op(KIND_DELETE) : fresh_op(KIND_DELETE);
    end else begin
      op.kind = KIND_UNUSED;
      op.hash = {$urandom(), $urandom()};
      op.key = KW'($urandom());
    end
    op_backlog.push_back(op);
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // input driver: presents queued operations, predicts each accepted transfer
  always @(posedge clk) begin
    map_op_t op;
    bit      taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        op.kind = in_kind;
        op.hash = in_hash_value;
        op.key = in_key;
        reply_due.push_back(apply_map_op(op));
        if (live_mirror > peak_live) peak_live = live_mirror;
        sent_count++;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap_left = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!in_valid || taken) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          op = op_backlog.pop_front();
          in_kind <= op.kind;
          in_hash_value <= op.hash;
          in_key <= op.key;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each transfer with the oldest prediction
  always @(posedge clk) begin
    map_reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reply_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual status %0d slot %0d count %0d",
                   $time, out_status, out_slot_index, out_occupied_count);
        end else begin
          want = reply_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("slot_index", 32'(want.slot), 32'(out_slot_index));
          check_field("occupied_count", 32'(want.count), 32'(out_occupied_count));
          status_seen[want.status]++;
        end
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_stall_left = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      out_stall <= (out_stall_left > 0);
      if (out_stall_left > 0) out_stall_left--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d of %0d sent, %0d results outstanding",
               $time, cycle_count, sent_count, op_total, reply_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CAP; i++) begin
      ctrl_mirror[i] = CTRL_EMPTY;
      key_mirror[i] = '0;
    end
    for (int i = 0; i < 6; i++) hot_home[i] = $urandom_range(0, CAP - 1);

    // extremes of hash and key, existing entry, unused operation
    queue_op(KIND_INSERT, '0, '0);
    queue_op(KIND_INSERT, '1, '1);
    queue_op(KIND_FIND, '0, '0);
    queue_op(KIND_FIND, '1, '0);
    queue_op(KIND_INSERT, '0, '0);
    queue_op(KIND_UNUSED, '1, '1);
    // same tag, different keys filling one group, then overflow
    for (int k = 100; k <= 104; k++) queue_op(KIND_INSERT, make_hash(20, 5), KW'(k));
    // freed slot in the home group takes a second copy of a later key
    queue_op(KIND_DELETE, make_hash(20, 5), KW'(101));
    queue_op(KIND_INSERT, make_hash(20, 5), KW'(104));
    queue_op(KIND_FIND, make_hash(20, 5), KW'(104));
    queue_op(KIND_DELETE, make_hash(20, 5), KW'(104));
    queue_op(KIND_FIND, make_hash(20, 5), KW'(104));
    queue_op(KIND_DELETE, make_hash(20, 5), KW'(999));
    queue_op(KIND_DELETE, '1, '1);
    queue_op(KIND_FIND, '1, '1);
    queue_op(KIND_DELETE, '0, '0);
    // last group fills, the next insert wraps to group zero
    for (int k = 7; k <= 11; k++) queue_op(KIND_INSERT, make_hash(CAP - 2, 9), KW'(k));

    // fill to a full table, drain it, then mixed traffic
    for (int i = 0; i < 750; i++) queue_random_op(75, 13, 10);
    for (int i = 0; i < 500; i++) queue_random_op(12, 25, 61);
    for (int i = 0; i < 450; i++) queue_random_op(40, 30, 28);
    op_total = op_backlog.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < op_total) @(posedge clk);
    while (reply_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d operations: %0d found, %0d inserted, %0d deleted, %0d absent or full",
             op_total, status_seen[ST_FOUND], status_seen[ST_INSERTED],
             status_seen[ST_DELETED], status_seen[ST_ABSENT]);
    $display("peak occupancy %0d of %0d slots, %0d mismatches", peak_live, CAP, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
